### hw/rtl/dsrs_pkg.sv
// dsrs_pkg: shared types and constants of the display screen rotation sequencer
// holds item, result and register-file types, command codes and reset values
// no dependencies
package dsrs_pkg;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    KIND_POLL       = 3'd0,
    KIND_SET_SCREEN = 3'd1,
    KIND_SET_AUTO   = 3'd2,
    KIND_SET_DEST   = 3'd3,
    KIND_SET_CONG   = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DASH_DWELL    = 3'd0,
    REG_GAS_DWELL     = 3'd1,
    REG_CLIMATE_DWELL = 3'd2,
    REG_GUIDE_TOGGLE  = 3'd3,
    REG_TRAIN_SHOW    = 3'd4,
    REG_TRAIN_REDRAW  = 3'd5,
    REG_IDLE_REDRAW   = 3'd6
  } reg_idx_t;

  localparam logic [1:0] SCR_DASH    = 2'd0;
  localparam logic [1:0] SCR_GAS     = 2'd1;
  localparam logic [1:0] SCR_CLIMATE = 2'd2;
  localparam logic [1:0] SCR_TRAIN   = 2'd3;

  localparam logic [1:0] DEST_NONE = 2'd0;
  localparam logic [7:0] DEST_MAX  = 8'd2;
  localparam logic [7:0] SCR_MAX   = 8'd3;

  localparam logic [15:0] DASH_DWELL_RST    = 16'd10000;
  localparam logic [15:0] GAS_DWELL_RST     = 16'd5000;
  localparam logic [15:0] CLIMATE_DWELL_RST = 16'd5000;
  localparam logic [15:0] GUIDE_TOGGLE_RST  = 16'd2000;
  localparam logic [15:0] TRAIN_SHOW_RST    = 16'd10000;
  localparam logic [15:0] TRAIN_REDRAW_RST  = 16'd120;
  localparam logic [15:0] IDLE_REDRAW_RST   = 16'd5000;
  localparam logic [15:0] LEVELS_RST        = 16'd6226;

  typedef struct packed {
    logic [15:0] dash_dwell;
    logic [15:0] gas_dwell;
    logic [15:0] climate_dwell;
    logic [15:0] guide_toggle;
    logic [15:0] train_show;
    logic [15:0] train_redraw;
    logic [15:0] idle_redraw;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic [7:0]  value;
    logic [15:0] congestion;
  } item_t;

  typedef struct packed {
    logic              clear_display;
    logic              draw;
    logic [1:0]        screen;
    logic              guide_mode;
    logic [1:0]        train_dest;
    logic signed [3:0] text_offset;
    logic [15:0]       congestion_out;
    logic              play_guide;
  } result_t;

  // wrapping interval check
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] since,
                                   input logic [15:0] period);
    logic [31:0] diff;
    diff = now - since;
    return diff >= {16'd0, period};
  endfunction

endpackage

### hw/rtl/dsrs_cfg_regs.sv
// dsrs_cfg_regs: the seven interval registers and their write port
// depends on dsrs_pkg
module dsrs_cfg_regs
  import dsrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [15:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_DASH_DWELL:    cfg_nxt.dash_dwell    = wr_data;
        REG_GAS_DWELL:     cfg_nxt.gas_dwell     = wr_data;
        REG_CLIMATE_DWELL: cfg_nxt.climate_dwell = wr_data;
        REG_GUIDE_TOGGLE:  cfg_nxt.guide_toggle  = wr_data;
        REG_TRAIN_SHOW:    cfg_nxt.train_show    = wr_data;
        REG_TRAIN_REDRAW:  cfg_nxt.train_redraw  = wr_data;
        REG_IDLE_REDRAW:   cfg_nxt.idle_redraw   = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dash_dwell    <= DASH_DWELL_RST;
      cfg_r.gas_dwell     <= GAS_DWELL_RST;
      cfg_r.climate_dwell <= CLIMATE_DWELL_RST;
      cfg_r.guide_toggle  <= GUIDE_TOGGLE_RST;
      cfg_r.train_show    <= TRAIN_SHOW_RST;
      cfg_r.train_redraw  <= TRAIN_REDRAW_RST;
      cfg_r.idle_redraw   <= IDLE_REDRAW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### hw/rtl/dsrs_core.sv
// dsrs_core: sequencer state and the single-pass update for one request
// depends on dsrs_pkg
module dsrs_core
  import dsrs_pkg::*;
#(
  parameter int OFFSET_SWING = 6
)
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    commit,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  localparam logic signed [4:0] SWING_POS = 5'(OFFSET_SWING);
  localparam logic signed [4:0] SWING_NEG = -5'(OFFSET_SWING);

  logic [1:0]        cur_screen_r, cur_screen_nxt;
  logic              auto_on_r, auto_on_nxt;
  logic              guide_state_r, guide_state_nxt;
  logic              dirty_flag_r, dirty_flag_nxt;
  logic              train_on_r, train_on_nxt;
  logic [1:0]        dest_id_r, dest_id_nxt;
  logic signed [3:0] offset_now_r, offset_now_nxt;
  logic              offset_step_down_r, offset_step_down_nxt;
  logic [31:0]       refresh_stamp_r, refresh_stamp_nxt;
  logic [31:0]       switch_stamp_r, switch_stamp_nxt;
  logic [31:0]       toggle_stamp_r, toggle_stamp_nxt;
  logic [31:0]       train_stamp_r, train_stamp_nxt;
  logic [15:0]       levels_r, levels_nxt;

  logic              clr;
  logic              draw;
  logic              play;
  logic              changed;
  logic [15:0]       stay;
  logic [15:0]       period;
  logic [1:0]        dest;
  logic signed [4:0] off_step;
  logic              kind_known;

  always_comb begin
    cur_screen_nxt       = cur_screen_r;
    auto_on_nxt          = auto_on_r;
    guide_state_nxt      = guide_state_r;
    dirty_flag_nxt       = dirty_flag_r;
    train_on_nxt         = train_on_r;
    dest_id_nxt          = dest_id_r;
    offset_now_nxt       = offset_now_r;
    offset_step_down_nxt = offset_step_down_r;
    refresh_stamp_nxt    = refresh_stamp_r;
    switch_stamp_nxt     = switch_stamp_r;
    toggle_stamp_nxt     = toggle_stamp_r;
    train_stamp_nxt      = train_stamp_r;
    levels_nxt           = levels_r;
    clr                  = 1'b0;
    draw                 = 1'b0;
    play                 = 1'b0;
    changed              = 1'b0;
    stay                 = cfg.climate_dwell;
    period               = cfg.idle_redraw;
    dest                 = DEST_NONE;
    off_step             = '0;
    kind_known           = 1'b1;

    unique case (item.kind)
      KIND_POLL: begin
        if (train_on_r) begin
          if (cur_screen_nxt != SCR_TRAIN) begin
            clr               = 1'b1;
            cur_screen_nxt    = SCR_TRAIN;
            changed           = 1'b1;
            switch_stamp_nxt  = item.now_ms;
            refresh_stamp_nxt = '0;
          end
          if (elapsed(item.now_ms, train_stamp_r, cfg.train_show)) begin
            train_on_nxt = 1'b0;
            if (auto_on_r) begin
              clr              = 1'b1;
              cur_screen_nxt   = SCR_DASH;
              dirty_flag_nxt   = 1'b1;
              guide_state_nxt  = 1'b0;
              toggle_stamp_nxt = item.now_ms;
              switch_stamp_nxt = item.now_ms;
              changed          = 1'b1;
            end
          end
        end
        // rotation
        priority if (cur_screen_nxt == SCR_DASH) begin
          stay = cfg.dash_dwell;
        end else if (cur_screen_nxt == SCR_GAS) begin
          stay = cfg.gas_dwell;
        end else begin
          stay = cfg.climate_dwell;
        end
        if (auto_on_r && cur_screen_nxt != SCR_TRAIN &&
            elapsed(item.now_ms, switch_stamp_nxt, stay)) begin
          clr              = 1'b1;
          switch_stamp_nxt = item.now_ms;
          changed          = 1'b1;
          if (cur_screen_nxt == SCR_CLIMATE) begin
            cur_screen_nxt   = SCR_DASH;
            dirty_flag_nxt   = 1'b1;
            guide_state_nxt  = 1'b0;
            toggle_stamp_nxt = item.now_ms;
            play             = 1'b1;
          end else begin
            cur_screen_nxt = cur_screen_nxt + 2'd1;
          end
        end
        // guide toggle
        if (cur_screen_nxt == SCR_DASH &&
            elapsed(item.now_ms, toggle_stamp_nxt, cfg.guide_toggle)) begin
          guide_state_nxt  = ~guide_state_nxt;
          toggle_stamp_nxt = item.now_ms;
          dirty_flag_nxt   = 1'b1;
        end
        period = (cur_screen_nxt == SCR_TRAIN) ? cfg.train_redraw : cfg.idle_redraw;
        draw = changed || (cur_screen_nxt == SCR_DASH && dirty_flag_nxt) ||
               elapsed(item.now_ms, refresh_stamp_nxt, period);
        if (draw) begin
          if (cur_screen_nxt == SCR_DASH) begin
            dirty_flag_nxt = 1'b0;
          end else if (cur_screen_nxt == SCR_TRAIN) begin
            // bounce the text offset
            off_step = offset_step_down_r ? (5'(offset_now_r) - 5'sd1)
                                          : (5'(offset_now_r) + 5'sd1);
            priority if (off_step >= SWING_POS) begin
              offset_now_nxt       = 4'(SWING_POS);
              offset_step_down_nxt = 1'b1;
            end else if (off_step <= SWING_NEG) begin
              offset_now_nxt       = 4'(SWING_NEG);
              offset_step_down_nxt = 1'b0;
            end else begin
              offset_now_nxt = 4'(off_step);
            end
          end
          refresh_stamp_nxt = item.now_ms;
        end
      end
      KIND_SET_SCREEN: begin
        if (item.value <= SCR_MAX) begin
          clr               = 1'b1;
          cur_screen_nxt    = item.value[1:0];
          switch_stamp_nxt  = item.now_ms;
          refresh_stamp_nxt = '0;
        end
      end
      KIND_SET_AUTO: begin
        auto_on_nxt = (item.value != 8'd0);
        if (auto_on_nxt) begin
          cur_screen_nxt   = SCR_DASH;
          dirty_flag_nxt   = 1'b1;
          guide_state_nxt  = 1'b0;
          toggle_stamp_nxt = item.now_ms;
        end
        clr               = 1'b1;
        switch_stamp_nxt  = item.now_ms;
        refresh_stamp_nxt = '0;
      end
      KIND_SET_DEST: begin
        dest        = (item.value > DEST_MAX) ? DEST_NONE : item.value[1:0];
        dest_id_nxt = dest;
        if (dest != DEST_NONE) begin
          train_on_nxt         = 1'b1;
          train_stamp_nxt      = item.now_ms;
          offset_now_nxt       = '0;
          offset_step_down_nxt = 1'b0;
        end else begin
          train_on_nxt = 1'b0;
        end
        if (cur_screen_r == SCR_TRAIN) begin
          refresh_stamp_nxt = '0;
        end
      end
      KIND_SET_CONG: begin
        if (item.congestion != levels_r) begin
          dirty_flag_nxt = 1'b1;
        end
        levels_nxt = item.congestion;
      end
      default: begin
        kind_known = 1'b0;
      end
    endcase
  end

  // offset shown is the pre-step value, or the fresh one after a destination write
  always_comb begin
    res.clear_display  = clr & kind_known;
    res.draw           = draw;
    res.screen         = cur_screen_nxt;
    res.guide_mode     = guide_state_nxt;
    res.train_dest     = dest_id_nxt;
    res.text_offset    = (item.kind == KIND_SET_DEST) ? offset_now_nxt : offset_now_r;
    res.congestion_out = levels_nxt;
    res.play_guide     = play;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_screen_r       <= SCR_DASH;
      auto_on_r          <= 1'b1;
      guide_state_r      <= 1'b0;
      dirty_flag_r       <= 1'b1;
      train_on_r         <= 1'b0;
      dest_id_r          <= DEST_NONE;
      offset_now_r       <= '0;
      offset_step_down_r <= 1'b0;
      refresh_stamp_r    <= '0;
      switch_stamp_r     <= '0;
      toggle_stamp_r     <= '0;
      train_stamp_r      <= '0;
      levels_r           <= LEVELS_RST;
    end else if (commit) begin
      cur_screen_r       <= cur_screen_nxt;
      auto_on_r          <= auto_on_nxt;
      guide_state_r      <= guide_state_nxt;
      dirty_flag_r       <= dirty_flag_nxt;
      train_on_r         <= train_on_nxt;
      dest_id_r          <= dest_id_nxt;
      offset_now_r       <= offset_now_nxt;
      offset_step_down_r <= offset_step_down_nxt;
      refresh_stamp_r    <= refresh_stamp_nxt;
      switch_stamp_r     <= switch_stamp_nxt;
      toggle_stamp_r     <= toggle_stamp_nxt;
      train_stamp_r      <= train_stamp_nxt;
      levels_r           <= levels_nxt;
    end
  end

endmodule

### hw/rtl/display_screen_rotation_sequencer_unit.sv
// Screen sequencer for a matrix display. Each request (poll or command with a
// millisecond timestamp) produces exactly one result with clear, draw and audio
// cue flags plus the current screen state. Throughput is one request per clock
// while the result register is free or being taken: a request accepted into the input
// register passes the single-pass update logic and is offered from the result
// register. A stalled result holds the request behind it.
// Interval registers are written through the cfg port, which is always ready.
// depends on dsrs_pkg, dsrs_cfg_regs, dsrs_core
module display_screen_rotation_sequencer_unit
  import dsrs_pkg::*;
#(
  parameter int OFFSET_SWING = 6
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_kind,
  input  logic [31:0]          in_now_ms,
  input  logic [7:0]           in_value,
  input  logic [15:0]          in_congestion,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_clear_display,
  output logic                 out_draw,
  output logic [1:0]           out_screen,
  output logic                 out_guide_mode,
  output logic [1:0]           out_train_dest,
  output logic signed [3:0]    out_text_offset,
  output logic [15:0]          out_congestion_out,
  output logic                 out_play_guide,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    advance;
  cfg_t    cfg;
  result_t res;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  dsrs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  dsrs_core #(
    .OFFSET_SWING (OFFSET_SWING)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .item   (in_item_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.kind       <= in_kind;
      in_item_r.now_ms     <= in_now_ms;
      in_item_r.value      <= in_value;
      in_item_r.congestion <= in_congestion;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_clear_display  = out_res_r.clear_display;
  assign out_draw           = out_res_r.draw;
  assign out_screen         = out_res_r.screen;
  assign out_guide_mode     = out_res_r.guide_mode;
  assign out_train_dest     = out_res_r.train_dest;
  assign out_text_offset    = out_res_r.text_offset;
  assign out_congestion_out = out_res_r.congestion_out;
  assign out_play_guide     = out_res_r.play_guide;

endmodule

### tb/sv/display_screen_rotation_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// testbench for display_screen_rotation_sequencer_unit: directed and random requests
// checked against a built-in scoreboard that predicts every result
// depends on dsrs_pkg and the display_screen_rotation_sequencer_unit rtl
module display_screen_rotation_sequencer_unit_tb
  import dsrs_pkg::*;
;

  localparam int OFFSET_SWING = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_REQUESTS = 275;
  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_MID = 3'd6;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;

  class screen_sequencer_scoreboard;
    logic [15:0]       cfg_regs [NUM_REGS];
    logic [1:0]        cur_screen;
    logic              auto_on;
    logic              guide_state;
    logic              dirty_flag;
    logic              train_on;
    logic [1:0]        dest_id;
    logic signed [3:0] offset_now;
    logic              step_down;
    logic [31:0]       refresh_stamp;
    logic [31:0]       switch_stamp;
    logic [31:0]       toggle_stamp;
    logic [31:0]       train_stamp;
    logic [15:0]       levels;
    result_t           screen_results_due [$];
    int                failures;

    function new();
      cfg_regs[REG_DASH_DWELL]    = DASH_DWELL_RST;
      cfg_regs[REG_GAS_DWELL]     = GAS_DWELL_RST;
      cfg_regs[REG_CLIMATE_DWELL] = CLIMATE_DWELL_RST;
      cfg_regs[REG_GUIDE_TOGGLE]  = GUIDE_TOGGLE_RST;
      cfg_regs[REG_TRAIN_SHOW]    = TRAIN_SHOW_RST;
      cfg_regs[REG_TRAIN_REDRAW]  = TRAIN_REDRAW_RST;
      cfg_regs[REG_IDLE_REDRAW]   = IDLE_REDRAW_RST;
      cur_screen = SCR_DASH;
      auto_on = 1'b1;
      guide_state = 1'b0;
      dirty_flag = 1'b1;
      train_on = 1'b0;
      dest_id = DEST_NONE;
      offset_now = '0;
      step_down = 1'b0;
      refresh_stamp = '0;
      switch_stamp = '0;
      toggle_stamp = '0;
      train_stamp = '0;
      levels = LEVELS_RST;
      failures = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] data);
      cfg_regs[idx] = data;
    endfunction

    function int outstanding();
      return screen_results_due.size();
    endfunction

    function logic interval_done(logic [31:0] now, logic [31:0] since, logic [15:0] period);
      return (now - since) >= 32'(period);
    endfunction

    function void step_offset();
      int o;
      o = offset_now + (step_down ? -1 : 1);
      if (o >= OFFSET_SWING) begin
        o = OFFSET_SWING;
        step_down = 1'b1;
      end else if (o <= -OFFSET_SWING) begin
        o = -OFFSET_SWING;
        step_down = 1'b0;
      end
      offset_now = 4'(o);
    endfunction

    function result_t predict_screen_result(item_t it);
      result_t     r;
      logic        changed;
      logic [15:0] stay;
      logic [15:0] period;
      logic [31:0] now;
      now = it.now_ms;
      r = '0;
      r.text_offset = offset_now;
      case (it.kind)
        KIND_POLL: begin
          changed = 1'b0;
          if (train_on) begin
            if (cur_screen != SCR_TRAIN) begin
              r.clear_display = 1'b1;
              cur_screen = SCR_TRAIN;
              changed = 1'b1;
              switch_stamp = now;
              refresh_stamp = '0;
            end
            if (interval_done(now, train_stamp, cfg_regs[REG_TRAIN_SHOW])) begin
              train_on = 1'b0;
              if (auto_on) begin
                r.clear_display = 1'b1;
                cur_screen = SCR_DASH;
                dirty_flag = 1'b1;
                guide_state = 1'b0;
                toggle_stamp = now;
                switch_stamp = now;
                changed = 1'b1;
              end
            end
          end
          stay = (cur_screen == SCR_DASH) ? cfg_regs[REG_DASH_DWELL] :
                 (cur_screen == SCR_GAS)  ? cfg_regs[REG_GAS_DWELL]  :
                                            cfg_regs[REG_CLIMATE_DWELL];
          if (auto_on && cur_screen != SCR_TRAIN && interval_done(now, switch_stamp, stay)) begin
            r.clear_display = 1'b1;
            cur_screen = (cur_screen == SCR_CLIMATE) ? SCR_DASH : cur_screen + 2'd1;
            switch_stamp = now;
            changed = 1'b1;
            if (cur_screen == SCR_DASH) begin
              dirty_flag = 1'b1;
              guide_state = 1'b0;
              toggle_stamp = now;
              r.play_guide = 1'b1;
            end
          end
          if (cur_screen == SCR_DASH &&
              interval_done(now, toggle_stamp, cfg_regs[REG_GUIDE_TOGGLE])) begin
            guide_state = ~guide_state;
            toggle_stamp = now;
            dirty_flag = 1'b1;
          end
          r.draw = changed;
          if (cur_screen == SCR_DASH && dirty_flag) r.draw = 1'b1;
          period = (cur_screen == SCR_TRAIN) ? cfg_regs[REG_TRAIN_REDRAW] :
                                               cfg_regs[REG_IDLE_REDRAW];
          if (interval_done(now, refresh_stamp, period)) r.draw = 1'b1;
          if (r.draw) begin
            if (cur_screen == SCR_DASH) begin
              dirty_flag = 1'b0;
            end else if (cur_screen == SCR_TRAIN) begin
              r.text_offset = offset_now;
              step_offset();
            end
            refresh_stamp = now;
          end
        end
        KIND_SET_SCREEN: begin
          if (it.value <= SCR_MAX) begin
            r.clear_display = 1'b1;
            cur_screen = it.value[1:0];
            switch_stamp = now;
            refresh_stamp = '0;
          end
        end
        KIND_SET_AUTO: begin
          auto_on = (it.value != 8'd0);
          if (auto_on) begin
            cur_screen = SCR_DASH;
            dirty_flag = 1'b1;
            guide_state = 1'b0;
            toggle_stamp = now;
          end
          r.clear_display = 1'b1;
          switch_stamp = now;
          refresh_stamp = '0;
        end
        KIND_SET_DEST: begin
          dest_id = (it.value > DEST_MAX) ? DEST_NONE : it.value[1:0];
          if (dest_id != DEST_NONE) begin
            train_on = 1'b1;
            train_stamp = now;
            offset_now = '0;
            step_down = 1'b0;
          end else begin
            train_on = 1'b0;
          end
          if (cur_screen == SCR_TRAIN) refresh_stamp = '0;
          r.text_offset = offset_now;
        end
        KIND_SET_CONG: begin
          if (it.congestion != levels) dirty_flag = 1'b1;
          levels = it.congestion;
        end
        default: begin
        end
      endcase
      r.screen = cur_screen;
      r.guide_mode = guide_state;
      r.train_dest = dest_id;
      r.congestion_out = levels;
      return r;
    endfunction

    function void note_request(item_t it);
      screen_results_due.push_back(predict_screen_result(it));
    endfunction

    function string show(result_t r);
      return $sformatf("clr=%0b draw=%0b scr=%0d guide=%0b dest=%0d off=%0d lv=%h play=%0b",
                       r.clear_display, r.draw, r.screen, r.guide_mode, r.train_dest,
                       r.text_offset, r.congestion_out, r.play_guide);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (screen_results_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) $display("unexpected result: %s", show(got));
        return;
      end
      want = screen_results_due.pop_front();
      if (got.clear_display !== want.clear_display || got.draw !== want.draw ||
          got.screen !== want.screen || got.guide_mode !== want.guide_mode ||
          got.train_dest !== want.train_dest || got.text_offset !== want.text_offset ||
          got.congestion_out !== want.congestion_out || got.play_guide !== want.play_guide) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [2:0]           in_kind;
  logic [31:0]          in_now_ms;
  logic [7:0]           in_value;
  logic [15:0]          in_congestion;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_clear_display;
  logic                 out_draw;
  logic [1:0]           out_screen;
  logic                 out_guide_mode;
  logic [1:0]           out_train_dest;
  logic signed [3:0]    out_text_offset;
  logic [15:0]          out_congestion_out;
  logic                 out_play_guide;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_wdata;

  screen_sequencer_scoreboard sb;
  int          sender_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  logic [31:0] time_base;

  display_screen_rotation_sequencer_unit #(.OFFSET_SWING(OFFSET_SWING)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_now_ms(in_now_ms),
    .in_value(in_value), .in_congestion(in_congestion),
    .out_valid(out_valid), .out_ready(out_ready), .out_clear_display(out_clear_display),
    .out_draw(out_draw), .out_screen(out_screen), .out_guide_mode(out_guide_mode),
    .out_train_dest(out_train_dest), .out_text_offset(out_text_offset),
    .out_congestion_out(out_congestion_out), .out_play_guide(out_play_guide),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("display_screen_rotation_sequencer_unit test failed");
    $finish;
  end

  function automatic item_t req(logic [2:0] kind, logic [31:0] now, logic [7:0] value,
                                logic [15:0] cong);
    item_t it;
    it.kind = kind;
    it.now_ms = now;
    it.value = value;
    it.congestion = cong;
    return it;
  endfunction

  function automatic item_t random_request(int unsigned step_max);
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    time_base = time_base + $urandom_range(0, step_max);
    it = req(KIND_POLL, time_base, 8'($urandom), 16'($urandom));
    if (pick < 68) begin
      it.kind = KIND_POLL;
    end else if (pick < 74) begin
      it.kind = KIND_SET_SCREEN;
      if ($urandom_range(0, 3) != 0) it.value = 8'($urandom_range(0, SCR_MAX));
    end else if (pick < 79) begin
      it.kind = KIND_SET_AUTO;
      if ($urandom_range(0, 3) != 0) it.value = ($urandom_range(0, 3) != 0) ? 8'd1 : 8'd0;
    end else if (pick < 87) begin
      it.kind = KIND_SET_DEST;
      if ($urandom_range(0, 4) != 0) it.value = 8'($urandom_range(0, DEST_MAX));
    end else if (pick < 94) begin
      it.kind = KIND_SET_CONG;
      if ($urandom_range(0, 3) == 0) it.congestion = sb.levels;
    end else if (pick < 97) begin
      it.kind = 3'($urandom_range(KIND_RESERVED_LO, KIND_RESERVED_HI));
    end else begin
      // off-timeline noise
      it.kind = 3'($urandom);
      it.now_ms = $urandom;
    end
    return it;
  endfunction

  task automatic send_request(item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= it.kind;
    in_now_ms <= it.now_ms;
    in_value <= it.value;
    in_congestion <= it.congestion;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic [15:0] vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(reg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_request(req(KIND_POLL, 32'd0, 8'd0, 16'd0));
    send_request(req(KIND_POLL, 32'd5000, 8'hFF, 16'hFFFF));
    send_request(req(KIND_SET_CONG, 32'd5100, 8'd0, LEVELS_RST));
    send_request(req(KIND_SET_CONG, 32'd5200, 8'd0, 16'hFFFF));
    send_request(req(KIND_SET_CONG, 32'd5300, 8'd0, 16'h0000));
    send_request(req(KIND_POLL, 32'd10000, 8'd0, 16'd0));
    send_request(req(KIND_SET_SCREEN, 32'd10100, 8'd200, 16'd0));
    send_request(req(KIND_SET_SCREEN, 32'd10200, 8'd2, 16'd0));
    // train screen with no event keeps animating
    send_request(req(KIND_SET_SCREEN, 32'd10300, 8'd3, 16'd0));
    send_request(req(KIND_POLL, 32'd10500, 8'd0, 16'd0));
    send_request(req(KIND_POLL, 32'd10700, 8'd0, 16'd0));
    send_request(req(KIND_SET_DEST, 32'd10800, 8'd1, 16'd0));
    send_request(req(KIND_POLL, 32'd10900, 8'd0, 16'd0));
    send_request(req(KIND_POLL, 32'd21000, 8'd0, 16'd0));
    send_request(req(KIND_SET_DEST, 32'd21100, 8'd2, 16'd0));
    send_request(req(KIND_POLL, 32'd21300, 8'd0, 16'd0));
    // destination out of range ends the event
    send_request(req(KIND_SET_DEST, 32'd21400, 8'd255, 16'd0));
    send_request(req(KIND_SET_DEST, 32'd21500, 8'd0, 16'd0));
    send_request(req(KIND_SET_AUTO, 32'd21600, 8'd0, 16'd0));
    send_request(req(KIND_POLL, 32'd40000, 8'd0, 16'd0));
    send_request(req(KIND_SET_AUTO, 32'd40100, 8'd255, 16'd0));
    send_request(req(KIND_SET_SCREEN, 32'd40200, 8'd4, 16'd0));
    send_request(req(KIND_RESERVED_LO, 32'd40300, 8'd1, 16'h1234));
    send_request(req(KIND_RESERVED_MID, 32'd40400, 8'd2, 16'h5678));
    send_request(req(KIND_RESERVED_HI, 32'd40500, 8'd3, 16'h9ABC));
    send_request(req(KIND_POLL, 32'hFFFF_FFFF, 8'd0, 16'd0));
    send_request(req(KIND_POLL, 32'h0000_0100, 8'd0, 16'd0));
  endtask

  initial begin
    result_t got;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.clear_display = out_clear_display;
        got.draw = out_draw;
        got.screen = out_screen;
        got.guide_mode = out_guide_mode;
        got.train_dest = out_train_dest;
        got.text_offset = out_text_offset;
        got.congestion_out = out_congestion_out;
        got.play_guide = out_play_guide;
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    logic [15:0] vals [NUM_REGS];
    int unsigned step_max;
    sb = new();
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    time_base = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_POLL;
    in_now_ms <= '0;
    in_value <= '0;
    in_congestion <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DASH_DWELL;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    time_base = 32'h0000_0100;

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct = 0;
          vals = '{16'd600, 16'd300, 16'd400, 16'd150, 16'd900, 16'd40, 16'd500};
          step_max = 120;
        end
        1: begin
          sender_idle_pct = 77;
          recv_stall_pct = 0;
          foreach (vals[i]) vals[i] = 16'hFFFF;
          step_max = 20000;
          // run across the timestamp wrap
          time_base = 32'hFFF0_0000;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct = 77;
          vals = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0};
          step_max = 3;
        end
        default: begin
          sender_idle_pct = 32;
          recv_stall_pct = 32;
          foreach (vals[i]) vals[i] = 16'($urandom_range(1, 3000));
          step_max = 400;
        end
      endcase
      write_settings(vals);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (phase == 0 && n == 100) hold_left = 300;
        if (phase == 3 && n == PHASE_REQUESTS / 2) begin
          in_valid <= 1'b0;
          while (sb.outstanding() != 0) @(posedge clk);
        end
        send_request(random_request(step_max));
      end
    end

    wait_idle();
    if (sb.outstanding() != 0) sb.failures++;
    if (sb.failures == 0) begin
      $display("display_screen_rotation_sequencer_unit test passed");
    end else begin
      $display("display_screen_rotation_sequencer_unit test failed");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dsrs_pkg.sv
hw/rtl/dsrs_cfg_regs.sv
hw/rtl/dsrs_core.sv
hw/rtl/display_screen_rotation_sequencer_unit.sv
tb/sv/display_screen_rotation_sequencer_unit_tb.sv
